[rtl/core/two_level_lru_cache_controller_assert.svh]
// Assertion macros for the cache controller RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef TWO_LEVEL_LRU_CACHE_CONTROLLER_ASSERT_SVH
`define TWO_LEVEL_LRU_CACHE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define TLLC_ASSERT_IMPL(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define TLLC_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

[rtl/core/tllc_pkg.sv]
// Shared types, codes and default geometry for the two-level cache controller.
// No dependencies.
package tllc_pkg;

  localparam int NEAR_SETS_DEF = 64;
  localparam int NEAR_WAYS_DEF = 4;
  localparam int FAR_SETS_DEF  = 512;
  localparam int FAR_WAYS_DEF  = 8;
  localparam int ADDR_BITS_DEF = 32;

  // register indexes
  localparam logic [2:0] REG_BLOCK_OFFSET = 3'd0;
  localparam logic [2:0] REG_L1_SET_BITS  = 3'd1;
  localparam logic [2:0] REG_L1_WAYS      = 3'd2;
  localparam logic [2:0] REG_L2_SET_BITS  = 3'd3;
  localparam logic [2:0] REG_L2_WAYS      = 3'd4;

  // register reset values
  localparam logic [3:0] RST_BLOCK_OFFSET = 4'd6;
  localparam logic [2:0] RST_L1_SET_BITS  = 3'd6;
  localparam logic [2:0] RST_L1_WAYS      = 3'd4;
  localparam logic [3:0] RST_L2_SET_BITS  = 4'd9;
  localparam logic [3:0] RST_L2_WAYS      = 4'd8;

  localparam logic [1:0] L1_RD_HIT  = 2'd0;
  localparam logic [1:0] L1_RD_MISS = 2'd1;
  localparam logic [1:0] L1_WR_HIT  = 2'd2;
  localparam logic [1:0] L1_WR_MISS = 2'd3;

  localparam logic [1:0] L2_NONE = 2'd0;
  localparam logic [1:0] L2_HIT  = 2'd1;
  localparam logic [1:0] L2_MISS = 2'd2;

  // effective (saturated) geometry
  typedef struct packed {
    logic [3:0] ob;
    logic [4:0] b1;
    logic [4:0] b2;
    logic [5:0] w1;
    logic [5:0] w2;
  } cfg_t;

  typedef struct packed {
    logic [1:0] l1_outcome;
    logic [1:0] l2_outcome;
    logic       vwb;
    logic       mrd;
    logic       mwb;
    logic       binv;
  } res_t;

endpackage

[rtl/core/two_level_lru_cache_controller.sv]
// The back-end sequencer takes one access at a time from the front queue and walks the
// tag row memories for it; the front keeps accepting accesses until that queue is full.
// Reset: synchronous; after it the tag rows of both levels are cleared with full held
// high; config writes are taken throughout.
module two_level_lru_cache_controller import tllc_pkg::*; #(
  parameter int NEAR_SETS = NEAR_SETS_DEF,
  parameter int NEAR_WAYS = NEAR_WAYS_DEF,
  parameter int FAR_SETS  = FAR_SETS_DEF,
  parameter int FAR_WAYS  = FAR_WAYS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // access side
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [31:0] address,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  l1_outcome,
  output logic [1:0]  l2_outcome,
  output logic        l1_victim_writeback,
  output logic        memory_read,
  output logic        memory_writeback,
  output logic        l1_back_invalidated,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int AW     = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int IW1    = (NEAR_SETS > 1) ? $clog2(NEAR_SETS) : 1;
  localparam int IW2    = (FAR_SETS > 1) ? $clog2(FAR_SETS) : 1;
  localparam int ITEM_W = 1 + IW1 + AW + IW2 + AW;

  cfg_t              eff;
  logic              clearing;
  logic              q_push, q_full, q_pop, q_empty;
  logic [ITEM_W-1:0] q_wdata, q_rdata;
  res_t              back_res, head;
  logic              res_push, res_full;
  logic [$bits(res_t)-1:0] head_bits;

  // front: config registers and address split into set index and tag per level
  tllc_front #(
    .NEAR_SETS(NEAR_SETS), .NEAR_WAYS(NEAR_WAYS), .FAR_SETS(FAR_SETS),
    .FAR_WAYS(FAR_WAYS), .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk, .rst, .push, .full, .op, .address,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .eff, .clearing, .q_full, .q_push, .q_data(q_wdata)
  );

  // short queue of classified accesses; front keeps accepting while back works
  tllc_fifo #(.W(ITEM_W)) u_mid (
    .clk, .rst, .wr_en(q_push), .wr_data(q_wdata), .full(q_full),
    .rd_en(q_pop), .rd_data(q_rdata), .empty(q_empty)
  );

  // back: tag memories and per-access sequencer
  tllc_back #(
    .NEAR_SETS(NEAR_SETS), .NEAR_WAYS(NEAR_WAYS), .FAR_SETS(FAR_SETS),
    .FAR_WAYS(FAR_WAYS), .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk, .rst, .eff, .mid_empty(q_empty), .mid_data(q_rdata), .mid_pop(q_pop),
    .res(back_res), .res_push, .res_full, .clearing
  );

  // result queue: a finished beat waits here; the back end stalls only while it is full
  tllc_fifo #(.W($bits(res_t))) u_res (
    .clk, .rst, .wr_en(res_push), .wr_data(back_res), .full(res_full),
    .rd_en(pop & ~empty), .rd_data(head_bits), .empty
  );

  assign head                = res_t'(head_bits);
  assign l1_outcome          = head.l1_outcome;
  assign l2_outcome          = head.l2_outcome;
  assign l1_victim_writeback = head.vwb;
  assign memory_read         = head.mrd;
  assign memory_writeback    = head.mwb;
  assign l1_back_invalidated = head.binv;

endmodule

[rtl/core/tllc_fifo.sv]
// Two-entry queue used between the front and back and on the result side.
// No package dependencies.
module tllc_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      cnt <= cnt + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

endmodule

[rtl/core/tllc_front.sv]
// Front end: configuration registers, geometry saturation and address split.
// Depends on tllc_pkg.
module tllc_front import tllc_pkg::*; #(
  parameter int NEAR_SETS = NEAR_SETS_DEF,
  parameter int NEAR_WAYS = NEAR_WAYS_DEF,
  parameter int FAR_SETS  = FAR_SETS_DEF,
  parameter int FAR_WAYS  = FAR_WAYS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  localparam int AW     = (ADDR_BITS < 32) ? ADDR_BITS : 32,
  localparam int IW1    = (NEAR_SETS > 1) ? $clog2(NEAR_SETS) : 1,
  localparam int IW2    = (FAR_SETS > 1) ? $clog2(FAR_SETS) : 1,
  localparam int ITEM_W = 1 + IW1 + AW + IW2 + AW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              op,
  input  logic [31:0]       address,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  output cfg_t              eff,
  input  logic              clearing,
  input  logic              q_full,
  output logic              q_push,
  output logic [ITEM_W-1:0] q_data
);

  localparam int N1B = $clog2(NEAR_SETS);
  localparam int N2B = $clog2(FAR_SETS);
  localparam int XW  = AW + IW1 + IW2;

  logic [3:0] block_offset_bits;
  logic [2:0] l1_set_bits;
  logic [2:0] l1_ways;
  logic [3:0] l2_set_bits;
  logic [3:0] l2_ways;

  logic [AW-1:0]  addr;
  logic [AW-1:0]  blk;
  logic [XW-1:0]  blkx;
  logic [IW1-1:0] m1;
  logic [IW2-1:0] m2;
  logic [IW1-1:0] i1;
  logic [IW2-1:0] i2;
  logic [AW-1:0]  t1;
  logic [AW-1:0]  t2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_offset_bits <= RST_BLOCK_OFFSET;
      l1_set_bits       <= RST_L1_SET_BITS;
      l1_ways           <= RST_L1_WAYS;
      l2_set_bits       <= RST_L2_SET_BITS;
      l2_ways           <= RST_L2_WAYS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLOCK_OFFSET: block_offset_bits <= cfg_data;
        REG_L1_SET_BITS:  l1_set_bits       <= cfg_data[2:0];
        REG_L1_WAYS:      l1_ways           <= cfg_data[2:0];
        REG_L2_SET_BITS:  l2_set_bits       <= cfg_data;
        REG_L2_WAYS:      l2_ways           <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate the raw registers to what the arrays hold
  always_comb begin
    eff.ob = (block_offset_bits > 4'd12) ? 4'd12 : block_offset_bits;
    eff.b1 = ({2'b0, l1_set_bits} > 5'(N1B)) ? 5'(N1B) : {2'b0, l1_set_bits};
    eff.b2 = ({1'b0, l2_set_bits} > 5'(N2B)) ? 5'(N2B) : {1'b0, l2_set_bits};
    if (l1_ways == 3'd0)                         eff.w1 = 6'd1;
    else if ({3'b0, l1_ways} > 6'(NEAR_WAYS))    eff.w1 = 6'(NEAR_WAYS);
    else                                         eff.w1 = {3'b0, l1_ways};
    if (l2_ways == 4'd0)                         eff.w2 = 6'd1;
    else if ({2'b0, l2_ways} > 6'(FAR_WAYS))     eff.w2 = 6'(FAR_WAYS);
    else                                         eff.w2 = {2'b0, l2_ways};
  end

  assign addr = address[AW-1:0];
  assign blk  = addr >> eff.ob;
  assign blkx = XW'(blk);
  assign m1   = ~({IW1{1'b1}} << eff.b1);
  assign m2   = ~({IW2{1'b1}} << eff.b2);
  assign i1   = blkx[IW1-1:0] & m1;
  assign i2   = blkx[IW2-1:0] & m2;
  assign t1   = blk >> eff.b1;
  assign t2   = blk >> eff.b2;

  assign full   = clearing | q_full;
  assign q_push = push & ~full;
  assign q_data = {op, i1, t1, i2, t2};

endmodule

[rtl/core/tllc_back.sv]
// Back end: L1/L2 tag row memories and the access sequencer.
// Depends on tllc_pkg and the assertion macro header.
`include "two_level_lru_cache_controller_assert.svh"

module tllc_back import tllc_pkg::*; #(
  parameter int NEAR_SETS = NEAR_SETS_DEF,
  parameter int NEAR_WAYS = NEAR_WAYS_DEF,
  parameter int FAR_SETS  = FAR_SETS_DEF,
  parameter int FAR_WAYS  = FAR_WAYS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  localparam int AW     = (ADDR_BITS < 32) ? ADDR_BITS : 32,
  localparam int IW1    = (NEAR_SETS > 1) ? $clog2(NEAR_SETS) : 1,
  localparam int IW2    = (FAR_SETS > 1) ? $clog2(FAR_SETS) : 1,
  localparam int ITEM_W = 1 + IW1 + AW + IW2 + AW
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              eff,
  input  logic              mid_empty,
  input  logic [ITEM_W-1:0] mid_data,
  output logic              mid_pop,
  output res_t              res,
  output logic              res_push,
  input  logic              res_full,
  output logic              clearing
);

  localparam int WW1  = (NEAR_WAYS > 1) ? $clog2(NEAR_WAYS) : 1;
  localparam int WW2  = (FAR_WAYS > 1) ? $clog2(FAR_WAYS) : 1;
  localparam int XW   = AW + IW1 + IW2;
  localparam int MAXS = (NEAR_SETS > FAR_SETS) ? NEAR_SETS : FAR_SETS;
  localparam int CW   = (MAXS > 1) ? $clog2(MAXS) : 1;

  typedef struct packed {
    logic [AW-1:0] tag;
    logic          valid;
    logic          dirty;
    logic [31:0]   stamp;
  } line_t;

  typedef line_t [NEAR_WAYS-1:0] nrow_t;
  typedef line_t [FAR_WAYS-1:0]  frow_t;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_L1    = 10'b00_0000_0100,
    S_WB    = 10'b00_0000_1000,
    S_L2RD  = 10'b00_0001_0000,
    S_L2    = 10'b00_0010_0000,
    S_BI    = 10'b00_0100_0000,
    S_FILL  = 10'b00_1000_0000,
    S_DONE  = 10'b01_0000_0000,
    S_SPARE = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  nrow_t near_mem [NEAR_SETS];
  frow_t far_mem  [FAR_SETS];

  nrow_t          n_rd, n_wdata, hold, hold_miss, bi_row;
  frow_t          f_rd, f_wdata;
  logic           n_re, n_we, f_re, f_we;
  logic [IW1-1:0] n_raddr, n_waddr;
  logic [IW2-1:0] f_raddr, f_waddr;

  logic [CW-1:0]  ccnt;
  logic [31:0]    count;
  logic [31:0]    now_r;
  logic           op_r;
  logic [IW1-1:0] i1_r, ei;
  logic [IW2-1:0] i2_r, xi;
  logic [AW-1:0]  t1_r, t2_r;
  logic [XW-1:0]  xt, et;
  logic [WW1-1:0] k_r;
  res_t           res_r;

  logic [IW1-1:0] m1, mid_i1, eb_i;
  logic [IW2-1:0] m2, vb_i;
  logic [XW-1:0]  vb, vb_t, eb, eb_t;
  logic           l1_f, wb_f, l2_f, bi_f;
  logic [WW1-1:0] l1_w, l1_v, bi_w;
  logic [WW2-1:0] wb_w, l2_w, l2_v;
  line_t          vline, fline;
  logic           hit_beat;

  function automatic logic [WW1:0] near_find(nrow_t row, logic [5:0] wn, logic [XW-1:0] tag);
    logic           f;
    logic [WW1-1:0] idx;
    f   = 1'b0;
    idx = '0;
    for (int w = 0; w < NEAR_WAYS; w++) begin
      if (!f && 6'(w) < wn && row[w].valid && XW'(row[w].tag) == tag) begin
        f   = 1'b1;
        idx = WW1'(w);
      end
    end
    return {f, idx};
  endfunction

  function automatic logic [WW2:0] far_find(frow_t row, logic [5:0] wn, logic [XW-1:0] tag);
    logic           f;
    logic [WW2-1:0] idx;
    f   = 1'b0;
    idx = '0;
    for (int w = 0; w < FAR_WAYS; w++) begin
      if (!f && 6'(w) < wn && row[w].valid && XW'(row[w].tag) == tag) begin
        f   = 1'b1;
        idx = WW2'(w);
      end
    end
    return {f, idx};
  endfunction

  // first empty way, else oldest stamp (lowest way on a tie)
  function automatic logic [WW1-1:0] near_victim(nrow_t row, logic [5:0] wn);
    logic           f;
    logic [WW1-1:0] idx;
    f   = 1'b0;
    idx = '0;
    for (int w = 0; w < NEAR_WAYS; w++) begin
      if (!f && 6'(w) < wn && !row[w].valid) begin
        f   = 1'b1;
        idx = WW1'(w);
      end
    end
    if (!f) begin
      for (int w = 1; w < NEAR_WAYS; w++) begin
        if (6'(w) < wn && row[w].stamp < row[idx].stamp) idx = WW1'(w);
      end
    end
    return idx;
  endfunction

  function automatic logic [WW2-1:0] far_victim(frow_t row, logic [5:0] wn);
    logic           f;
    logic [WW2-1:0] idx;
    f   = 1'b0;
    idx = '0;
    for (int w = 0; w < FAR_WAYS; w++) begin
      if (!f && 6'(w) < wn && !row[w].valid) begin
        f   = 1'b1;
        idx = WW2'(w);
      end
    end
    if (!f) begin
      for (int w = 1; w < FAR_WAYS; w++) begin
        if (6'(w) < wn && row[w].stamp < row[idx].stamp) idx = WW2'(w);
      end
    end
    return idx;
  endfunction

  // row memories, registered read
  always_ff @(posedge clk) begin
    if (n_re) n_rd <= near_mem[n_raddr];
    if (n_we) near_mem[n_waddr] <= n_wdata;
  end

  always_ff @(posedge clk) begin
    if (f_re) f_rd <= far_mem[f_raddr];
    if (f_we) far_mem[f_waddr] <= f_wdata;
  end

  assign mid_i1 = mid_data[ITEM_W-2 -: IW1];
  assign m1     = ~({IW1{1'b1}} << eff.b1);
  assign m2     = ~({IW2{1'b1}} << eff.b2);

  assign {l1_f, l1_w} = near_find(n_rd, eff.w1, XW'(t1_r));
  assign l1_v  = near_victim(n_rd, eff.w1);
  assign vline = n_rd[l1_v];
  // block address of the L1 victim, recut for the L2 geometry
  assign vb    = (XW'(vline.tag) << eff.b1) | XW'(i1_r);
  assign vb_i  = vb[IW2-1:0] & m2;
  assign vb_t  = vb >> eff.b2;

  // L1 row with the victim dropped, held until the refill
  always_comb begin
    hold_miss             = n_rd;
    hold_miss[l1_v].valid = 1'b0;
    hold_miss[l1_v].dirty = 1'b0;
  end

  assign {wb_f, wb_w} = far_find(f_rd, eff.w2, xt);
  assign {l2_f, l2_w} = far_find(f_rd, eff.w2, XW'(t2_r));
  assign l2_v  = far_victim(f_rd, eff.w2);
  assign fline = f_rd[l2_v];
  assign eb    = (XW'(fline.tag) << eff.b2) | XW'(i2_r);
  assign eb_i  = eb[IW1-1:0] & m1;
  assign eb_t  = eb >> eff.b1;

  // back-invalidation may land in the set already held for the refill
  assign bi_row = (ei == i1_r) ? hold : n_rd;
  assign {bi_f, bi_w} = near_find(bi_row, eff.w1, et);

  assign clearing = (state == S_CLEAR);
  assign res      = res_r;
  assign hit_beat = res_push && (res_r.l1_outcome inside {L1_RD_HIT, L1_WR_HIT});

  always_comb begin
    state_next = state;
    mid_pop    = 1'b0;
    res_push   = 1'b0;
    n_re       = 1'b0;
    n_raddr    = i1_r;
    n_we       = 1'b0;
    n_waddr    = i1_r;
    n_wdata    = hold;
    f_re       = 1'b0;
    f_raddr    = i2_r;
    f_we       = 1'b0;
    f_waddr    = i2_r;
    f_wdata    = f_rd;
    case (state)
      S_CLEAR: begin
        n_we    = (32'(ccnt) < NEAR_SETS);
        n_waddr = ccnt[IW1-1:0];
        n_wdata = '0;
        f_we    = (32'(ccnt) < FAR_SETS);
        f_waddr = ccnt[IW2-1:0];
        f_wdata = '0;
        if (ccnt == CW'(MAXS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (!mid_empty) begin
          mid_pop    = 1'b1;
          n_re       = 1'b1;
          n_raddr    = mid_i1;
          state_next = S_L1;
        end
      end
      S_L1: begin
        if (l1_f) begin
          n_we                 = 1'b1;
          n_wdata              = n_rd;
          n_wdata[l1_w].stamp  = now_r;
          if (op_r) n_wdata[l1_w].dirty = 1'b1;
          state_next           = S_DONE;
        end else if (vline.valid && vline.dirty) begin
          f_re       = 1'b1;
          f_raddr    = vb_i;
          state_next = S_WB;
        end else begin
          f_re       = 1'b1;
          state_next = S_L2;
        end
      end
      S_WB: begin
        if (wb_f) begin
          f_we                = 1'b1;
          f_waddr             = xi;
          f_wdata[wb_w].dirty = 1'b1;
          f_wdata[wb_w].stamp = now_r;
        end
        state_next = S_L2RD;
      end
      S_L2RD: begin
        f_re       = 1'b1;
        state_next = S_L2;
      end
      S_L2: begin
        f_we = 1'b1;
        if (l2_f) begin
          f_wdata[l2_w].stamp = now_r;
          state_next          = S_FILL;
        end else begin
          f_wdata[l2_v] = '{tag: t2_r, valid: 1'b1, dirty: 1'b0, stamp: now_r};
          if (fline.valid) begin
            n_re       = 1'b1;
            n_raddr    = eb_i;
            state_next = S_BI;
          end else begin
            state_next = S_FILL;
          end
        end
      end
      S_BI: begin
        if (bi_f && ei != i1_r) begin
          n_we                = 1'b1;
          n_waddr             = ei;
          n_wdata             = bi_row;
          n_wdata[bi_w].valid = 1'b0;
          n_wdata[bi_w].dirty = 1'b0;
        end
        state_next = S_FILL;
      end
      S_FILL: begin
        n_we         = 1'b1;
        n_wdata[k_r] = '{tag: t1_r, valid: 1'b1, dirty: op_r, stamp: now_r};
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ccnt  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: ccnt <= ccnt + 1'b1;
        S_IDLE: begin
          if (!mid_empty) begin
            {op_r, i1_r, t1_r, i2_r, t2_r} <= mid_data;
            now_r <= count;
            count <= count + 32'd1;
            res_r <= '0;
          end
        end
        S_L1: begin
          if (l1_f) begin
            res_r.l1_outcome <= op_r ? L1_WR_HIT : L1_RD_HIT;
            res_r.l2_outcome <= L2_NONE;
          end else begin
            res_r.l1_outcome  <= op_r ? L1_WR_MISS : L1_RD_MISS;
            hold              <= hold_miss;
            k_r               <= l1_v;
            if (vline.valid && vline.dirty) begin
              res_r.vwb <= 1'b1;
              xi        <= vb_i;
              xt        <= vb_t;
            end
          end
        end
        S_WB: if (!wb_f) res_r.mwb <= 1'b1;
        S_L2: begin
          if (l2_f) begin
            res_r.l2_outcome <= L2_HIT;
          end else begin
            res_r.l2_outcome <= L2_MISS;
            res_r.mrd        <= 1'b1;
            if (fline.valid) begin
              if (fline.dirty) res_r.mwb <= 1'b1;
              ei <= eb_i;
              et <= eb_t;
            end
          end
        end
        S_BI: begin
          if (bi_f) begin
            res_r.binv <= 1'b1;
            if (bi_row[bi_w].dirty) res_r.mwb <= 1'b1;
            if (ei == i1_r) begin
              hold[bi_w].valid <= 1'b0;
              hold[bi_w].dirty <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `TLLC_ASSERT_IMPL(a_push_room, clk, rst, res_push, !res_full, "result beat into full queue")
  `TLLC_ASSERT_IMPL(a_no_pop_clear, clk, rst, state == S_CLEAR, !mid_pop, "pop during clear")
  `TLLC_ASSERT_IMPL(a_binv_miss, clk, rst, res_push && res_r.binv, res_r.mrd, "binv on L2 hit")
  `TLLC_ASSERT_IMPL(a_hit_no_l2, clk, rst, hit_beat, res_r.l2_outcome == L2_NONE, "L2 used on hit")
  `TLLC_ASSERT_NEXT(a_fill_done, clk, rst, state == S_FILL, state == S_DONE, "fill not done")

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for the two-level inclusive LRU cache controller.
// Depends on tllc_pkg and the controller RTL; predicts every access result.
module testbench;
  import tllc_pkg::*;

  localparam int NS = NEAR_SETS_DEF;
  localparam int NW = NEAR_WAYS_DEF;
  localparam int FS = FAR_SETS_DEF;
  localparam int FW = FAR_WAYS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        op = 1'b0;
  logic [31:0] address = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  l1_outcome, l2_outcome;
  logic        l1_victim_writeback, memory_read, memory_writeback, l1_back_invalidated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  always #5 clk = ~clk;

  two_level_lru_cache_controller i_dut (.*);

  // ---------------------------------------------------------------------------
  // Predictor state: tag arrays of both levels plus the geometry registers
  // ---------------------------------------------------------------------------
  logic [31:0] l1_tag [NS*NW];
  logic        l1_vld [NS*NW];
  logic        l1_drt [NS*NW];
  logic [31:0] l1_stp [NS*NW];
  logic [31:0] l2_tag [FS*FW];
  logic        l2_vld [FS*FW];
  logic        l2_drt [FS*FW];
  logic [31:0] l2_stp [FS*FW];
  logic [31:0] stamp_now;
  logic [3:0]  r_ob, r_b2s, r_w2;
  logic [2:0]  r_b1, r_w1;

  res_t        pending_res [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          long_hold = 1'b0;

  function automatic int clamp_bits(int b, int lim);
    while (b > 0 && (1 << b) > lim) b--;
    return b;
  endfunction

  function automatic int clamp_ways(int w, int lim);
    if (w < 1) return 1;
    return (w > lim) ? lim : w;
  endfunction

  function automatic int l1_lookup(int base, int ways, logic [63:0] tag);
    for (int w = 0; w < ways; w++)
      if (l1_vld[base+w] && 64'(l1_tag[base+w]) == tag) return w;
    return -1;
  endfunction

  function automatic int l2_lookup(int base, int ways, logic [63:0] tag);
    for (int w = 0; w < ways; w++)
      if (l2_vld[base+w] && 64'(l2_tag[base+w]) == tag) return w;
    return -1;
  endfunction

  function automatic int l1_victim(int base, int ways);
    int best;
    best = 0;
    for (int w = 0; w < ways; w++) if (!l1_vld[base+w]) return w;
    for (int w = 1; w < ways; w++) if (l1_stp[base+w] < l1_stp[base+best]) best = w;
    return best;
  endfunction

  function automatic int l2_victim(int base, int ways);
    int best;
    best = 0;
    for (int w = 0; w < ways; w++) if (!l2_vld[base+w]) return w;
    for (int w = 1; w < ways; w++) if (l2_stp[base+w] < l2_stp[base+best]) best = w;
    return best;
  endfunction

  function automatic void cache_reset();
    for (int i = 0; i < NS*NW; i++) begin
      l1_tag[i] = '0; l1_vld[i] = 0; l1_drt[i] = 0; l1_stp[i] = '0;
    end
    for (int i = 0; i < FS*FW; i++) begin
      l2_tag[i] = '0; l2_vld[i] = 0; l2_drt[i] = 0; l2_stp[i] = '0;
    end
    stamp_now = '0;
    r_ob = RST_BLOCK_OFFSET; r_b1 = RST_L1_SET_BITS; r_w1 = RST_L1_WAYS;
    r_b2s = RST_L2_SET_BITS; r_w2 = RST_L2_WAYS;
  endfunction

  // one access through both levels; returns the flags the block must report
  function automatic res_t cache_access(logic wr, logic [31:0] addr);
    res_t r;
    int ob, b1, b2, w1, w2, base1, base2, hw, k, fw, vbase, f, ebase, nw;
    logic [31:0] blk, m1, m2, t1, t2, now;
    logic [63:0] vb, eb;
    ob = (r_ob > 12) ? 12 : r_ob;
    blk = addr >> ob;
    b1 = clamp_bits(r_b1, NS); b2 = clamp_bits(r_b2s, FS);
    w1 = clamp_ways(r_w1, NW); w2 = clamp_ways(r_w2, FW);
    m1 = (32'd1 << b1) - 1; m2 = (32'd1 << b2) - 1;
    now = stamp_now;
    stamp_now = now + 1;
    base1 = int'(blk & m1) * NW; base2 = int'(blk & m2) * FW;
    t1 = blk >> b1; t2 = blk >> b2;
    r = '0;
    hw = l1_lookup(base1, w1, 64'(t1));
    if (hw >= 0) begin
      l1_stp[base1+hw] = now;
      if (wr) l1_drt[base1+hw] = 1'b1;
      r.l1_outcome = wr ? L1_WR_HIT : L1_RD_HIT;
      r.l2_outcome = L2_NONE;
      return r;
    end
    k = base1 + l1_victim(base1, w1);
    r.l1_outcome = wr ? L1_WR_MISS : L1_RD_MISS;
    if (l1_vld[k] && l1_drt[k]) begin
      // dirty L1 victim folds into its L2 copy, or memory if inclusion was lost
      vb = (64'(l1_tag[k]) << b1) | 64'(blk & m1);
      vbase = int'(vb & 64'(m2)) * FW;
      fw = l2_lookup(vbase, w2, vb >> b2);
      r.vwb = 1'b1;
      if (fw >= 0) begin
        l2_drt[vbase+fw] = 1'b1; l2_stp[vbase+fw] = now;
      end else r.mwb = 1'b1;
    end
    l1_vld[k] = 1'b0; l1_drt[k] = 1'b0;
    hw = l2_lookup(base2, w2, 64'(t2));
    if (hw >= 0) begin
      l2_stp[base2+hw] = now;
      r.l2_outcome = L2_HIT;
    end else begin
      f = base2 + l2_victim(base2, w2);
      r.l2_outcome = L2_MISS;
      r.mrd = 1'b1;
      if (l2_vld[f]) begin
        // L2 eviction: back-invalidate the L1 copy
        eb = (64'(l2_tag[f]) << b2) | 64'(blk & m2);
        ebase = int'(eb & 64'(m1)) * NW;
        nw = l1_lookup(ebase, w1, eb >> b1);
        if (l2_drt[f]) r.mwb = 1'b1;
        if (nw >= 0) begin
          if (l1_drt[ebase+nw]) r.mwb = 1'b1;
          l1_vld[ebase+nw] = 1'b0; l1_drt[ebase+nw] = 1'b0;
          r.binv = 1'b1;
        end
      end
      l2_tag[f] = t2; l2_vld[f] = 1'b1; l2_drt[f] = 1'b0; l2_stp[f] = now;
    end
    l1_tag[k] = t1; l1_vld[k] = 1'b1; l1_drt[k] = wr; l1_stp[k] = now;
    return r;
  endfunction

  function automatic void reg_apply(logic [2:0] idx, logic [3:0] val);
    case (idx)
      REG_BLOCK_OFFSET: r_ob = val;
      REG_L1_SET_BITS:  r_b1 = val[2:0];
      REG_L1_WAYS:      r_w1 = val[2:0];
      REG_L2_SET_BITS:  r_b2s = val;
      REG_L2_WAYS:      r_w2 = val;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------
  task automatic cfg_write(logic [2:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_apply(idx, val);
  endtask

  // offer one access beat; prediction is queued at the accepting edge
  task automatic send_access(logic wr, logic [31:0] addr);
    res_t p;
    push <= 1'b1; op <= wr; address <= addr;
    do @(posedge clk); while (full);
    p = cache_access(wr, addr);
    pending_res = {pending_res, p};
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // bursts with random gaps; gap lowers push before idling
  task automatic send_burst_gap();
    if ($urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern plus one long hold-off
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst || long_hold) pop <= 1'b0;
    else case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      default: pop <= ($urandom_range(0, 1) == 0);
    endcase
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
  end

  always @(posedge clk) begin
    res_t got, exp;
    if (!rst && pop && !empty) begin
      got = '{l1_outcome, l2_outcome, l1_victim_writeback, memory_read,
              memory_writeback, l1_back_invalidated};
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp = pending_res.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: rows either carry a typed expectation or rely on the predictor
  // ---------------------------------------------------------------------------
  typedef struct {
    logic        wr;
    logic [31:0] addr;
    bit          typed;
    res_t        want;
  } row_t;

  row_t dir_rows[$];

  task automatic run_directed();
    res_t p;
    // cold reads and writes at the address extremes, then hits and evictions
    dir_rows = '{
      '{1'b0, 32'h0000_0000, 1, '{L1_RD_MISS, L2_MISS, 0, 1, 0, 0}},
      '{1'b0, 32'h0000_003F, 1, '{L1_RD_HIT, L2_NONE, 0, 0, 0, 0}},
      '{1'b1, 32'h0000_0010, 1, '{L1_WR_HIT, L2_NONE, 0, 0, 0, 0}},
      '{1'b1, 32'hFFFF_FFFF, 1, '{L1_WR_MISS, L2_MISS, 0, 1, 0, 0}},
      '{1'b0, 32'hFFFF_FFC0, 1, '{L1_RD_HIT, L2_NONE, 0, 0, 0, 0}},
      '{1'b1, 32'h5555_5555, 0, '0}, '{1'b0, 32'hAAAA_AAAA, 0, '0},
      '{1'b1, 32'h0001_0000, 0, '0}, '{1'b1, 32'h0002_0000, 0, '0},
      '{1'b1, 32'h0003_0000, 0, '0}, '{1'b1, 32'h0004_0000, 0, '0},
      '{1'b0, 32'h0005_0000, 0, '0}, '{1'b0, 32'h0000_0000, 0, '0},
      '{1'b0, 32'h0001_0000, 0, '0}, '{1'b1, 32'h8000_0000, 0, '0}
    };
    foreach (dir_rows[i]) begin
      push <= 1'b1; op <= dir_rows[i].wr; address <= dir_rows[i].addr;
      do @(posedge clk); while (full);
      p = cache_access(dir_rows[i].wr, dir_rows[i].addr);
      if (dir_rows[i].typed && p !== dir_rows[i].want) begin
        mismatches++;
        if (mismatches <= 10) $display("row %0d predictor %p table %p", i, p, dir_rows[i].want);
      end
      pending_res = {pending_res, p};
    end
    drain();
  endtask

  // tiny geometry: 1 L1 set x 1 way, 1 L2 set x 2 ways; forces back-invalidates
  task automatic run_tiny_directed();
    cfg_write(REG_BLOCK_OFFSET, 4'd0);
    cfg_write(REG_L1_SET_BITS, 4'd0);
    cfg_write(REG_L1_WAYS, 4'd0);
    cfg_write(REG_L2_SET_BITS, 4'd0);
    cfg_write(REG_L2_WAYS, 4'd2);
    for (int i = 0; i < 8; i++) send_access(i[0], 32'(i % 3));
    drain();
  endtask

  // random accesses over a small block pool so hits, evictions and dirty
  // traffic all occur; occasional full-range address noise
  task automatic run_random(int n, int pool);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) a = $urandom();
      else a = ($urandom_range(0, pool - 1) << $urandom_range(0, 12)) ^ $urandom_range(0, 15);
      send_access(1'($urandom_range(0, 1)), a);
      send_burst_gap();
    end
    drain();
  endtask

  task automatic random_config();
    cfg_write(REG_BLOCK_OFFSET, 4'($urandom_range(0, 15)));
    cfg_write(REG_L1_SET_BITS, 4'($urandom_range(0, 7)));
    cfg_write(REG_L1_WAYS, 4'($urandom_range(0, 7)));
    cfg_write(REG_L2_SET_BITS, 4'($urandom_range(0, 15)));
    cfg_write(REG_L2_WAYS, 4'($urandom_range(0, 15)));
  endtask

  // long receiver hold while the sender keeps offering, to back up the block
  initial begin
    wait (!rst);
    wait (push && pending_res.size() > 0 && cycles > 2000);
    long_hold = 1'b1;
    repeat (300) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    cache_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_tiny_directed();
    // extremes: everything saturated, then the reset geometry again
    cfg_write(REG_BLOCK_OFFSET, 4'd15);
    cfg_write(REG_L1_SET_BITS, 4'd7);
    cfg_write(REG_L1_WAYS, 4'd7);
    cfg_write(REG_L2_SET_BITS, 4'd15);
    cfg_write(REG_L2_WAYS, 4'd15);
    run_random(150, 64);
    for (int ph = 0; ph < 5; ph++) begin
      random_config();
      run_random(120, 16);
    end
    cfg_write(REG_BLOCK_OFFSET, RST_BLOCK_OFFSET);
    cfg_write(REG_L1_SET_BITS, 4'(RST_L1_SET_BITS));
    cfg_write(REG_L1_WAYS, 4'(RST_L1_WAYS));
    cfg_write(REG_L2_SET_BITS, RST_L2_SET_BITS);
    cfg_write(REG_L2_WAYS, RST_L2_WAYS);
    run_random(80, 1024);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
